>>> hdl/half_float_format_converter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the half float format converter
// ----------------------------------------------------------------------------
`ifndef HALF_FLOAT_FORMAT_CONVERTER_MACROS_SVH
`define HALF_FLOAT_FORMAT_CONVERTER_MACROS_SVH

// Implication checked on every clock edge, disabled in reset.
`define HFC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define HFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/hfc_pkg.sv
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types and constants of the half float format converter.
// ----------------------------------------------------------------------------
package hfc_pkg;

   localparam int ValueWidth = 32;
   localparam int OpWidth    = 2;
   localparam int StageCount = 3;

   localparam logic [OpWidth-1:0] OP_H2S  = 2'd0;
   localparam logic [OpWidth-1:0] OP_S2H  = 2'd1;
   localparam logic [OpWidth-1:0] OP_BF2S = 2'd2;
   localparam logic [OpWidth-1:0] OP_S2BF = 2'd3;

   localparam logic [31:0] EXP32_MASK  = 32'h7f80_0000;
   localparam logic [31:0] MANT32_MASK = 32'h007f_ffff;
   localparam logic [15:0] BF_QUIET    = 16'h0040;
   localparam logic [31:0] BF_BIAS     = 32'h0000_7fff;
   localparam logic [15:0] H_QNAN      = 16'h7e00;
   localparam logic [15:0] H_INF       = 16'h7c00;
   localparam logic [12:0] H_DROP_MASK = 13'h1fff;
   localparam logic [12:0] H_DROP_HALF = 13'h1000;
   localparam int          Rebias      = 127 - 15;

   typedef struct packed {
      logic [OpWidth-1:0]    operation;
      logic [ValueWidth-1:0] value_bits;
   } req_type;

   typedef struct packed {
      logic [ValueWidth-1:0] result_bits;
   } rsp_type;

   // Stage 1 -> stage 2 working set
   typedef struct packed {
      logic [OpWidth-1:0] op;
      logic               sign;
      logic [15:0]        fast;      // finished result for trivial paths
      logic               done;      // fast holds the answer
      logic [7:0]         efield;
      logic [23:0]        mant;      // with hidden bit where relevant
      logic [4:0]         shift;     // right shift for narrowing / left for widening
      logic [31:0]        wide;      // widening / bf narrowing result
   } mid_type;

endpackage

>>> hdl/hfc_stream_if.sv
// ----------------------------------------------------------------------------
// hfc_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface hfc_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/hfc_convert_pipe.sv
// ----------------------------------------------------------------------------
// hfc_convert_pipe
// Three-stage conversion datapath with stall-capable valid pipeline.
// ----------------------------------------------------------------------------
`include "half_float_format_converter_macros.svh"

module hfc_convert_pipe import hfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic [StageCount-1:0] valid_ff, valid_in;
   logic [StageCount-1:0] adv;
   req_type               s1_ff;
   mid_type               s2_ff, s2_in;
   rsp_type               s3_ff, s3_in;

   // stage enables: a stage moves when it is empty or the next one moves
   always_comb begin
      adv[StageCount-1] = !valid_ff[StageCount-1] || out_ready;
      for (int i = StageCount-2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[StageCount-1];
   assign out_data  = s3_ff;

   always_comb begin
      valid_in = valid_ff;
      if (adv[0]) valid_in[0] = in_valid;
      for (int i = 1; i < StageCount; i++) begin
         if (adv[i]) valid_in[i] = valid_ff[i-1];
      end
   end

   // stage 2: field decode and classification
   always_comb begin
      logic [31:0] b;
      logic [4:0]  he;
      logic [9:0]  hm;
      logic [4:0]  lz;
      logic signed [9:0] e;
      logic [31:0] bsum;
      b      = s1_ff.value_bits;
      he     = b[14:10];
      hm     = b[9:0];
      e      = $signed({2'b00, b[30:23]}) - 10'sd112;
      bsum   = b + BF_BIAS + {31'd0, b[16]};
      s2_in  = '0;
      s2_in.op     = s1_ff.operation;
      s2_in.efield = b[30:23];
      lz = 5'd0;
      for (int k = 0; k <= 9; k++) begin
         if (hm[k]) lz = 5'(10 - k);
      end
      unique case (s1_ff.operation)
         OP_H2S: begin
            s2_in.sign  = b[15];
            s2_in.done  = 1'b0;
            s2_in.mant  = {14'd0, hm};
            s2_in.shift = lz;
            if (he == 5'd0 && hm == 10'd0)
               s2_in.wide = {b[15], 31'd0};
            else if (he == 5'd0)
               s2_in.wide = {b[15], 8'(Rebias + 1) - {3'd0, lz}, 23'd0};
            else if (he == 5'h1f)
               s2_in.wide = {b[15], 8'hff, hm, 13'd0};
            else
               s2_in.wide = {b[15], 8'({3'd0, he} + 8'(Rebias)), hm, 13'd0};
         end
         OP_S2H: begin
            s2_in.sign = b[31];
            s2_in.mant = {1'b1, b[22:0]};
            s2_in.wide = b;
            if (b[30:23] == 8'hff) begin
               s2_in.done = 1'b1;
               s2_in.fast = (b[22:0] != 23'd0) ? {b[31], H_QNAN[14:0]}
                                               : {b[31], H_INF[14:0]};
            end else if (e >= 10'sd31) begin
               s2_in.done = 1'b1;
               s2_in.fast = {b[31], H_INF[14:0]};
            end else if (e < -10'sd10) begin
               s2_in.done = 1'b1;
               s2_in.fast = {b[31], 15'd0};
            end else if (e <= 10'sd0) begin
               s2_in.shift = 5'(10'sd14 - e);
            end else begin
               s2_in.shift = 5'd13;
            end
         end
         OP_BF2S: begin
            s2_in.wide = {b[15:0], 16'd0};
         end
         OP_S2BF: begin
            if ((b & EXP32_MASK) == EXP32_MASK && (b & MANT32_MASK) != 32'd0)
               s2_in.wide = {16'd0, b[31:16] | BF_QUIET};
            else
               s2_in.wide = {16'd0, bsum[31:16]};
         end
         default: s2_in = '0;
      endcase
   end

   // stage 3: widening mantissa normalize, narrowing rounding
   always_comb begin
      logic [23:0] hmx, rem, half;
      logic [11:0] rnd;
      logic        up;
      logic [7:0]  ex;
      s3_in.result_bits = s2_ff.wide;
      hmx  = s2_ff.mant >> s2_ff.shift;
      rem  = s2_ff.mant & ((24'd1 << s2_ff.shift) - 24'd1);
      half = 24'd1 << (s2_ff.shift - 5'd1);
      up   = (rem > half) || (rem == half && hmx[0]);
      // normal path keeps the hidden bit in bit 10, so a carry lands in bit 11
      rnd  = {1'b0, hmx[10:0]} + {11'd0, up};
      ex   = s2_ff.efield - 8'(Rebias);
      unique case (s2_ff.op)
         OP_H2S: begin
            if (s2_ff.wide[30:23] == 8'd0 || s2_ff.wide[30:23] == 8'hff
                || s2_ff.wide[22:0] != 23'd0)
               s3_in.result_bits = s2_ff.wide;
            else
               s3_in.result_bits = {s2_ff.wide[31:23],
                  5'(s2_ff.mant[9:0] << s2_ff.shift) == 5'd0 ?
                  {10'(s2_ff.mant[9:0] << s2_ff.shift), 13'd0} :
                  {10'(s2_ff.mant[9:0] << s2_ff.shift), 13'd0}};
         end
         OP_S2H: begin
            if (s2_ff.done)
               s3_in.result_bits = {16'd0, s2_ff.fast};
            else if (s2_ff.shift != 5'd13)
               s3_in.result_bits = {16'd0, s2_ff.sign, 4'd0, rnd[10:0]};
            else if (rnd[11]) begin
               if (ex + 8'd1 >= 8'd31)
                  s3_in.result_bits = {16'd0, s2_ff.sign, H_INF[14:0]};
               else
                  s3_in.result_bits = {16'd0, s2_ff.sign, 5'(ex + 8'd1), 10'd0};
            end else
               s3_in.result_bits = {16'd0, s2_ff.sign, ex[4:0], rnd[9:0]};
         end
         OP_BF2S, OP_S2BF: s3_in.result_bits = s2_ff.wide;
         default: s3_in.result_bits = s2_ff.wide;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (adv[0]) s1_ff <= in_data;
      if (adv[1]) s2_ff <= s2_in;
      if (adv[2]) s3_ff <= s3_in;
   end

   `HFC_ASSERT_NEXT(a_hold_out, clock, reset, out_valid && !out_ready, out_valid && $stable(s3_ff), "stalled result changed")
   `HFC_ASSERT_IMP(a_full_stall, clock, reset, (&valid_ff) && !out_ready, !in_ready, "accepted into a full stalled pipe")
   `HFC_ASSERT_NEXT(a_s2h_hi, clock, reset, out_valid && s2_ff.op == OP_S2H && adv[2] && valid_ff[1], out_data.result_bits[31:16] == 16'd0, "narrow result upper bits set")

endmodule

>>> hdl/half_float_format_converter.sv
// ----------------------------------------------------------------------------
// half_float_format_converter
// Streams binary16 / bfloat16 / binary32 bit-pattern conversions.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | operation[1:0], value_bits[31:0]
//  rsp     | out | result_bits[31:0]
//
//  One transaction per cycle sustained while rsp is ready; data passes through the
//  three register stages (capture, decode/classify, round/normalize).
//  reset clears the stage valid bits only; payload registers are not reset.
//  A stall at rsp holds each full stage with no empty stage after it; empty
//  stages still fill, so no transaction is dropped or repeated.
// ----------------------------------------------------------------------------
module half_float_format_converter import hfc_pkg::*; (
   input logic         clock,
   input logic         reset,
   hfc_stream_if.sink   req,
   hfc_stream_if.source rsp
);

   req_type req_data;
   rsp_type rsp_data;

   // unpack the request transaction
   assign req_data = req.payload;
   assign rsp.payload = rsp_data;

   hfc_convert_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_data   (req_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp_data)
   );

endmodule
